// ===== hdl/srsl_pkg.sv =====
// shared types, constants and helpers for the s-record stream loader
package srsl_pkg;

  localparam int ADDR_BITS_DEF = 32;

  typedef enum logic [3:0] {
    PH_TYPE0  = 4'd0,
    PH_TYPE1  = 4'd1,
    PH_COUNT0 = 4'd2,
    PH_COUNT1 = 4'd3,
    PH_ADDR   = 4'd4,
    PH_DATA   = 4'd5,
    PH_SUM0   = 4'd6,
    PH_SUM1   = 4'd7,
    PH_EOL    = 4'd8,
    PH_SKIP   = 4'd9,
    PH_DONE   = 4'd10,
    PH_CANCEL = 4'd11,
    PH_ABORT  = 4'd12
  } phase_t;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ABORT  = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_TYPE      = 4'd0;
  localparam logic [3:0] ERR_LEN_CHAR  = 4'd1;
  localparam logic [3:0] ERR_LEN_VALUE = 4'd2;
  localparam logic [3:0] ERR_ADDR      = 4'd3;
  localparam logic [3:0] ERR_UNEXP_DAT = 4'd4;
  localparam logic [3:0] ERR_DATA      = 4'd5;
  localparam logic [3:0] ERR_SUM_CHAR  = 4'd6;
  localparam logic [3:0] ERR_SUM_MATCH = 4'd7;
  localparam logic [3:0] ERR_EOL       = 4'd8;

  localparam logic [7:0] CHAR_ETX = 8'h03;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_F   = 8'h46;
  localparam logic [7:0] CHAR_S   = 8'h53;

  localparam logic [3:0] TYPE_HDR   = 4'd0;
  localparam logic [3:0] TYPE_D16   = 4'd1;
  localparam logic [3:0] TYPE_D24   = 4'd2;
  localparam logic [3:0] TYPE_D32   = 4'd3;
  localparam logic [3:0] TYPE_RSV   = 4'd4;
  localparam logic [3:0] TYPE_CNT16 = 4'd5;
  localparam logic [3:0] TYPE_CNT24 = 4'd6;
  localparam logic [3:0] TYPE_E32   = 4'd7;
  localparam logic [3:0] TYPE_E24   = 4'd8;
  localparam logic [3:0] TYPE_E16   = 4'd9;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [31:0] lowest_address;
    logic [31:0] highest_address;
    logic [3:0]  error_code;
    logic [31:0] record_number;
    logic [31:0] data_record_number;
  } result_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.ok  = 1'b0;
    h.val = c[3:0];
    if (c >= CHAR_0 && c <= CHAR_9) begin
      h.ok = 1'b1;
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      h.ok  = 1'b1;
      h.val = 4'(c[3:0] + 4'd9);
    end
    return h;
  endfunction

endpackage

// ===== hdl/srsl_core.sv =====
// record parser state machine: one character per step, at most one result
module srsl_core #(
  parameter int ADDR_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       char_code,
  output logic             res_valid,
  output srsl_pkg::result_t res
);
  import srsl_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [ADDR_BITS-1:0] cur_r, cur_nxt;
  logic [ADDR_BITS-1:0] low_r, low_nxt;
  logic [ADDR_BITS-1:0] high_r, high_nxt;
  logic [3:0]           adl_r, adl_nxt;
  logic [8:0]           ddl_r, ddl_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic                 odd_r, odd_nxt;
  logic                 final_r, final_nxt;
  logic [31:0]          rec_r, rec_nxt;
  logic [31:0]          drec_r, drec_nxt;

  hex_digit_t           dig;
  logic [7:0]           byte_dig;
  logic                 odd_dig;
  logic [7:0]           sum_dig;
  logic                 line_end;
  logic                 terminal;
  logic                 type_digit;
  logic [2:0]           addr_bytes;
  logic [7:0]           len_left;
  logic [3:0]           adl_dec;
  logic [8:0]           ddl_dec;
  logic                 emit;
  logic                 abort;
  logic [1:0]           kind;
  logic [3:0]           err;
  logic [ADDR_BITS-1:0] addr_full;
  logic [7:0]           data_out;
  logic [31:0]          addr32, low32, high32;

  assign dig        = hex_decode(char_code);
  assign byte_dig   = {byte_r[3:0], dig.val};
  assign odd_dig    = ~odd_r;
  // checksum covers count, address and data bytes
  assign sum_dig    = ((phase_r == PH_COUNT0 || phase_r == PH_COUNT1 ||
                        phase_r == PH_ADDR || phase_r == PH_DATA) && !odd_dig) ?
                      8'(sum_r + byte_dig) : sum_r;
  assign line_end   = (char_code == CHAR_CR) || (char_code == CHAR_LF);
  assign terminal   = (phase_r == PH_DONE) || (phase_r == PH_CANCEL) ||
                      (phase_r == PH_ABORT);
  assign type_digit = (char_code >= CHAR_0) && (char_code <= CHAR_9);
  assign addr_bytes = adl_r[3:1];
  assign len_left   = 8'(byte_dig - {5'd0, addr_bytes} - 8'd1);
  assign adl_dec    = 4'(adl_r - 4'd1);
  assign ddl_dec    = 9'(ddl_r - 9'd1);

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    adl_nxt   = adl_r;
    ddl_nxt   = ddl_r;
    byte_nxt  = byte_r;
    sum_nxt   = sum_r;
    odd_nxt   = odd_r;
    final_nxt = final_r;
    rec_nxt   = rec_r;
    drec_nxt  = drec_r;
    emit      = 1'b0;
    abort     = 1'b0;
    kind      = KIND_WRITE;
    err       = ERR_NONE;
    addr_full = '0;
    data_out  = 8'd0;

    if (terminal) begin
      phase_nxt = phase_r;
    end else if (char_code == CHAR_ETX) begin
      phase_nxt = PH_CANCEL;
      emit      = 1'b1;
      kind      = KIND_CANCEL;
    end else begin
      unique case (phase_r)
        PH_TYPE0: begin
          if (!line_end) begin
            cur_nxt  = '0;
            adl_nxt  = 4'd0;
            ddl_nxt  = 9'd0;
            byte_nxt = 8'd0;
            sum_nxt  = 8'd0;
            if (char_code == CHAR_S) begin
              phase_nxt = PH_TYPE1;
            end else begin
              abort = 1'b1;
              err   = ERR_TYPE;
            end
          end
        end
        PH_TYPE1: begin
          cur_nxt  = '0;
          adl_nxt  = 4'd0;
          ddl_nxt  = 9'd0;
          byte_nxt = 8'd0;
          sum_nxt  = 8'd0;
          rec_nxt  = rec_r + 32'd1;
          priority if (!type_digit) begin
            abort = 1'b1;
            err   = ERR_TYPE;
          end else if (char_code[3:0] == TYPE_HDR || char_code[3:0] == TYPE_RSV ||
                       char_code[3:0] == TYPE_CNT16 || char_code[3:0] == TYPE_CNT24) begin
            phase_nxt = PH_SKIP;
          end else if (char_code[3:0] == TYPE_D16 || char_code[3:0] == TYPE_D24 ||
                       char_code[3:0] == TYPE_D32) begin
            drec_nxt  = drec_r + 32'd1;
            adl_nxt   = 4'((char_code[3:0] + 4'd1) << 1);
            phase_nxt = PH_COUNT0;
          end else begin
            // end records carry 4, 3 or 2 address bytes for types 7, 8, 9
            adl_nxt   = 4'((4'd11 - char_code[3:0]) << 1);
            final_nxt = 1'b1;
            phase_nxt = PH_COUNT0;
          end
        end
        PH_COUNT0, PH_COUNT1: begin
          if (!dig.ok) begin
            abort = 1'b1;
            err   = ERR_LEN_CHAR;
          end else begin
            byte_nxt = byte_dig;
            odd_nxt  = odd_dig;
            sum_nxt  = sum_dig;
            if (phase_r == PH_COUNT0) begin
              phase_nxt = PH_COUNT1;
            end else if (byte_dig < ({5'd0, addr_bytes} + 8'd1)) begin
              abort = 1'b1;
              err   = ERR_LEN_VALUE;
            end else begin
              ddl_nxt   = {len_left, 1'b0};
              phase_nxt = PH_ADDR;
            end
          end
        end
        PH_ADDR: begin
          if (!dig.ok) begin
            abort = 1'b1;
            err   = ERR_ADDR;
          end else begin
            byte_nxt = byte_dig;
            odd_nxt  = odd_dig;
            sum_nxt  = sum_dig;
            adl_nxt  = adl_dec;
            if (!adl_dec[0]) begin
              cur_nxt = {cur_r[ADDR_BITS-9:0], byte_dig};
            end
            if (adl_dec == 4'd0) begin
              if (ddl_r != 9'd0) begin
                if (final_r) begin
                  abort = 1'b1;
                  err   = ERR_UNEXP_DAT;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end else begin
                phase_nxt = PH_SUM0;
              end
            end
          end
        end
        PH_DATA: begin
          if (!dig.ok) begin
            abort = 1'b1;
            err   = ERR_DATA;
          end else begin
            byte_nxt = byte_dig;
            odd_nxt  = odd_dig;
            sum_nxt  = sum_dig;
            ddl_nxt  = ddl_dec;
            if (ddl_dec == 9'd0) begin
              phase_nxt = PH_SUM0;
            end
            if (!ddl_dec[0]) begin
              low_nxt   = (cur_r < low_r) ? cur_r : low_r;
              high_nxt  = (cur_r > high_r) ? cur_r : high_r;
              cur_nxt   = cur_r + 1'b1;
              emit      = 1'b1;
              kind      = KIND_WRITE;
              addr_full = cur_r;
              data_out  = byte_dig;
            end
          end
        end
        PH_SUM0, PH_SUM1: begin
          if (!dig.ok) begin
            abort = 1'b1;
            err   = ERR_SUM_CHAR;
          end else begin
            byte_nxt = byte_dig;
            odd_nxt  = odd_dig;
            if (phase_r == PH_SUM0) begin
              phase_nxt = PH_SUM1;
            end else if (~sum_r != byte_dig) begin
              abort = 1'b1;
              err   = ERR_SUM_MATCH;
            end else begin
              phase_nxt = PH_EOL;
            end
          end
        end
        PH_EOL: begin
          if (!line_end) begin
            abort = 1'b1;
            err   = ERR_EOL;
          end else if (final_r) begin
            phase_nxt = PH_DONE;
            emit      = 1'b1;
            kind      = KIND_DONE;
            addr_full = cur_r;
          end else begin
            phase_nxt = PH_TYPE0;
          end
        end
        PH_SKIP: begin
          if (line_end) begin
            phase_nxt = PH_TYPE0;
          end
        end
        PH_DONE, PH_CANCEL, PH_ABORT: begin
          phase_nxt = phase_r;
        end
        default: begin
          phase_nxt = PH_ABORT;
        end
      endcase
      if (abort) begin
        phase_nxt = PH_ABORT;
        emit      = 1'b1;
        kind      = KIND_ABORT;
        addr_full = '0;
        data_out  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE0;
      cur_r   <= '0;
      low_r   <= '1;
      high_r  <= '0;
      adl_r   <= 4'd0;
      ddl_r   <= 9'd0;
      byte_r  <= 8'd0;
      sum_r   <= 8'd0;
      odd_r   <= 1'b0;
      final_r <= 1'b0;
      rec_r   <= 32'd0;
      drec_r  <= 32'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      adl_r   <= adl_nxt;
      ddl_r   <= ddl_nxt;
      byte_r  <= byte_nxt;
      sum_r   <= sum_nxt;
      odd_r   <= odd_nxt;
      final_r <= final_nxt;
      rec_r   <= rec_nxt;
      drec_r  <= drec_nxt;
    end
  end

  // report the low 32 address bits, zero-extended for narrow builds
  if (ADDR_BITS >= 32) begin : g_addr_wide
    assign addr32 = addr_full[31:0];
    assign low32  = low_nxt[31:0];
    assign high32 = high_nxt[31:0];
  end else begin : g_addr_narrow
    assign addr32 = {{(32-ADDR_BITS){1'b0}}, addr_full};
    assign low32  = {{(32-ADDR_BITS){1'b0}}, low_nxt};
    assign high32 = {{(32-ADDR_BITS){1'b0}}, high_nxt};
  end

  assign res_valid              = step_en && emit;
  assign res.result_kind        = kind;
  assign res.address            = addr32;
  assign res.data_byte          = data_out;
  assign res.lowest_address     = low32;
  assign res.highest_address    = high32;
  assign res.error_code         = err;
  assign res.record_number      = rec_nxt;
  assign res.data_record_number = drec_nxt;

`ifndef SYNTH
  a_terminal_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE || phase_r == PH_CANCEL || phase_r == PH_ABORT)
    |=> $stable(phase_r))
    else $error("terminal phase left before reset");

  a_no_result_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE || phase_r == PH_CANCEL || phase_r == PH_ABORT)
    |-> !res_valid)
    else $error("result produced after load ended");

  a_marks_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    !(low_r == '1 && high_r == '0) |-> (low_r <= high_r))
    else $error("lowest address mark above highest");

  a_addr_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ADDR) |-> (adl_r != 4'd0))
    else $error("address phase with no digits left");

  a_data_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (ddl_r != 9'd0 && !final_r))
    else $error("data phase with no digits or in end record");
`endif

endmodule

// ===== hdl/srsl_out_stage.sv =====
// result register with valid/stall handshake toward the consumer
module srsl_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  srsl_pkg::result_t res,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output srsl_pkg::result_t out_res
);
  import srsl_pkg::*;

  logic    valid_r;
  result_t res_r;

  // free when empty or when the held transaction leaves this cycle
  assign ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/srecord_stream_loader_unit.sv =====
// top level of the s-record stream loader: input register, parser, result register
// path: a character is held in the input register, steps the parser, and its result is held in the result register
// throughput: one character per cycle; the parser advances whenever the result
// register is empty or being drained, so only consumer stall slows intake
// reset: synchronous active-low rst_n returns the parser to expecting 'S',
// clears counters, sets the address marks to their empty values, and empties both registers
module srecord_stream_loader_unit #(
  parameter int ADDR_BITS = srsl_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_address,
  output logic [7:0]  out_data_byte,
  output logic [31:0] out_lowest_address,
  output logic [31:0] out_highest_address,
  output logic [3:0]  out_error_code,
  output logic [31:0] out_record_number,
  output logic [31:0] out_data_record_number
);
  import srsl_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       ready;
  logic       step_en;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign step_en  = in_valid_r && ready;
  assign in_stall = in_valid_r && !ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_char_code;
    end
  end

  srsl_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .char_code (in_char_r),
    .res_valid (res_valid),
    .res       (res)
  );

  srsl_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind        = out_res.result_kind;
  assign out_address            = out_res.address;
  assign out_data_byte          = out_res.data_byte;
  assign out_lowest_address     = out_res.lowest_address;
  assign out_highest_address    = out_res.highest_address;
  assign out_error_code         = out_res.error_code;
  assign out_record_number      = out_res.record_number;
  assign out_data_record_number = out_res.data_record_number;

endmodule
